/* design/bfsa_pkg.sv */
// Shared types and constants for the best-fit segment allocator.
// No dependencies; imported by every design file.
package bfsa_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int ADDR_BITS_DEF    = 32;

  localparam int SIZE_W = 32;   // stored segment payload size
  localparam int REQ_W  = 31;   // request and granted sizes
  localparam int WORD_W = 32;   // configuration and output address words

  localparam logic [REQ_W-1:0] REQ_MAX = '1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_HEAP    = 2'd1,
    STAT_TABLE_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MODIFY,
    ST_RESP
  } state_t;

  // table edit applied during the rewrite pass
  typedef struct packed {
    logic ins;
    logic wr;
    logic rem;
  } edit_t;

endpackage

/* design/best_fit_segment_allocator_core.sv */
// Best-fit segment allocator: the free table is a chain of MAX_SEGMENTS cells
// that rotates one entry per cycle, while it scans or rewrites, past a
// controller at its head. A request takes one full rotation to scan (best fit
// or insertion point), then, if the table changes, a second rotation that
// rewrites it with the edit applied. A heap-top allocation or out-of-heap
// result skips the rewrite; a free refused on a full table skips the scan too.
// Uses bfsa_pkg and bfsa_cell.
module best_fit_segment_allocator_core #(
  parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF,
  parameter int HEADER_BYTES = bfsa_pkg::HEADER_BYTES_DEF,
  parameter int ADDR_BITS    = bfsa_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [95:0]                 s_tdata,  // req_size, payload_addr, freed_size, pad
  input  logic                        s_tuser,  // op
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [63:0]                 m_tdata,  // grant_addr, granted_size, pad
  output logic [1:0]                  m_tuser,  // status
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [bfsa_pkg::WORD_W-1:0] cfg_data
);
  import bfsa_pkg::*;

  localparam int N     = MAX_SEGMENTS;
  localparam int IDX_W = $clog2(N);
  localparam int CNT_W = $clog2(N + 1);
  localparam int AB    = ADDR_BITS;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(N - 1);
  localparam logic [AB-1:0]    H_A  = AB'(HEADER_BYTES);
  localparam logic [33:0]      H_W  = 34'(HEADER_BYTES);

  function automatic logic [SIZE_W-1:0] sat_sum(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b);
    logic [33:0] s;
    s = {2'b0, a} + H_W + {2'b0, b};
    return (s[33:32] != 2'b0) ? '1 : s[31:0];
  endfunction

  // chain
  logic [AB-1:0]     cs [N];
  logic [SIZE_W-1:0] cz [N];
  logic [AB-1:0]     tail_start;
  logic [SIZE_W-1:0] tail_size;
  logic              shift;

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [AB-1:0]     nin_s;
    logic [SIZE_W-1:0] nin_z;
    if (k == N - 1) begin : g_tail
      assign nin_s = tail_start;
      assign nin_z = tail_size;
    end else begin : g_mid
      assign nin_s = cs[k+1];
      assign nin_z = cz[k+1];
    end
    bfsa_cell #(.ADDR_BITS(AB)) u_cell (
      .clk(clk), .shift(shift), .in_start(nin_s), .in_size(nin_z),
      .start(cs[k]), .size(cz[k])
    );
  end

  state_t            state, state_next;
  logic [IDX_W-1:0]  r;
  logic [CNT_W-1:0]  count;
  logic [WORD_W-1:0] heap_top, heap_base, heap_limit;
  logic              op_q;
  logic [REQ_W-1:0]  req_q, bsize_q;
  logic [AB-1:0]     hdr_q;

  logic              have, exact, found, prev_ok;
  logic [SIZE_W-1:0] best;
  logic [IDX_W-1:0]  pick;
  logic [AB-1:0]     pick_start, prev_start, next_start;
  logic [SIZE_W-1:0] pick_size, prev_size, next_size;

  edit_t             edit;
  logic [IDX_W-1:0]  wr_idx, rem_idx;
  logic [AB-1:0]     w_start, d_start;
  logic [SIZE_W-1:0] w_size, d_size;

  logic [WORD_W-1:0] res_addr;
  logic [REQ_W-1:0]  res_size;
  status_t           res_stat;

  logic [WORD_W-1:0] grant_addr;
  logic [REQ_W-1:0]  granted_size;
  status_t           status;

  logic              accept, head_ok;
  logic [AB-1:0]     head_s;
  logic [SIZE_W-1:0] head_z, slack;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {1'b0, granted_size, grant_addr};
  assign m_tuser   = status;
  assign shift     = (state == ST_SCAN) || (state == ST_MODIFY);
  assign head_s    = cs[0];
  assign head_z    = cz[0];
  assign head_ok   = CNT_W'(r) < count;
  assign slack     = head_z - {1'b0, req_q};

  always_comb begin
    tail_start = head_s;
    tail_size  = head_z;
    if (state == ST_MODIFY) begin
      if (edit.ins) begin
        if (r == wr_idx) begin
          tail_start = w_start;
          tail_size  = w_size;
        end else if (r > wr_idx) begin
          tail_start = d_start;
          tail_size  = d_size;
        end
      end else begin
        if (edit.rem && r >= rem_idx) begin
          tail_start = cs[1];
          tail_size  = cz[1];
        end
        if (edit.wr && r == wr_idx) begin
          tail_start = w_start;
          tail_size  = w_size;
        end
      end
    end
  end

  // decision on the scanned table
  logic [IDX_W-1:0]  pos;
  logic [AB-1:0]     s_end, p_end;
  logic              up, low, split;
  logic [SIZE_W-1:0] nsize, lsize;
  logic [32:0]       need;
  logic [33:0]       top_sum;

  always_comb begin
    pos     = found ? pick : count[IDX_W-1:0];
    s_end   = hdr_q + H_A + AB'(bsize_q);
    up      = found && (s_end == next_start);
    nsize   = up ? sat_sum({1'b0, bsize_q}, next_size) : {1'b0, bsize_q};
    p_end   = prev_start + H_A + AB'(prev_size);
    low     = prev_ok && (p_end == hdr_q);
    lsize   = sat_sum(prev_size, nsize);
    split   = {1'b0, pick_size} > ({2'b0, req_q} + 33'(HEADER_BYTES));
    need    = 33'(HEADER_BYTES) + {2'b0, req_q};
    top_sum = {2'b0, heap_top} + {1'b0, need};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (s_tuser == OP_FREE && count == CNT_W'(N)) ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN:   if (r == LAST) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (op_q == OP_ALLOC && !have) state_next = ST_RESP;
        else state_next = ST_MODIFY;
      end
      ST_MODIFY: if (r == LAST) state_next = ST_RESP;
      ST_RESP:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      heap_top   <= '0;
      heap_base  <= '0;
      heap_limit <= '1;
      m_tvalid   <= 1'b0;
      r          <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        if (cfg_index == REG_HEAP_BASE) heap_base <= cfg_data;
        else heap_limit <= cfg_data;
      end
      if (shift) r <= (r == LAST) ? '0 : r + 1'b1;
      if (state == ST_IDLE) r <= '0;
      if (state == ST_DECIDE) begin
        if (op_q == OP_ALLOC) begin
          if (have && !split) count <= count - 1'b1;
          else if (!have && top_sum <= {2'b0, heap_limit}) heap_top <= top_sum[31:0];
        end else begin
          if (!up && !low) count <= count + 1'b1;
          else if (up && low) count <= count - 1'b1;
        end
      end
      if (state == ST_RESP && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      op_q     <= s_tuser;
      req_q    <= s_tdata[30:0];
      hdr_q    <= AB'(s_tdata[62:31]) - H_A;
      bsize_q  <= s_tdata[93:63];
      have     <= 1'b0;
      exact    <= 1'b0;
      found    <= 1'b0;
      prev_ok  <= 1'b0;
      res_addr <= '0;
      res_size <= '0;
      res_stat <= STAT_TABLE_FULL;
    end
    if (state == ST_SCAN && head_ok) begin
      if (op_q == OP_ALLOC) begin
        if (!exact && head_z >= {1'b0, req_q} && (slack == '0 || !have || slack < best)) begin
          have       <= 1'b1;
          exact      <= (slack == '0);
          best       <= slack;
          pick       <= r;
          pick_start <= head_s;
          pick_size  <= head_z;
        end
      end else if (!found) begin
        if (hdr_q > head_s) begin
          prev_ok    <= 1'b1;
          prev_start <= head_s;
          prev_size  <= head_z;
        end else begin
          found      <= 1'b1;
          pick       <= r;
          next_start <= head_s;
          next_size  <= head_z;
        end
      end
    end
    if (state == ST_MODIFY) begin
      d_start <= head_s;
      d_size  <= head_z;
    end
    if (state == ST_DECIDE) begin
      if (op_q == OP_ALLOC) begin
        if (have) begin
          edit     <= '{ins: 1'b0, wr: split, rem: !split};
          res_stat <= STAT_OK;
          res_addr <= WORD_W'(pick_start + H_A);
          res_size <= split ? req_q :
                      ((pick_size > {1'b0, REQ_MAX}) ? REQ_MAX : pick_size[REQ_W-1:0]);
          wr_idx   <= pick;
          rem_idx  <= pick;
          w_start  <= pick_start + H_A + AB'(req_q);
          w_size   <= pick_size - {1'b0, req_q} - SIZE_W'(HEADER_BYTES);
        end else if (top_sum > {2'b0, heap_limit}) begin
          edit     <= '0;
          res_stat <= STAT_NO_HEAP;
          res_addr <= '0;
          res_size <= '0;
        end else begin
          edit     <= '0;
          res_stat <= STAT_OK;
          res_addr <= WORD_W'(AB'(heap_base) + AB'(heap_top) + H_A);
          res_size <= req_q;
        end
      end else begin
        edit     <= '{ins: !low && !up, wr: low || up, rem: low && up};
        res_stat <= STAT_OK;
        res_addr <= '0;
        res_size <= '0;
        rem_idx  <= pos;
        wr_idx   <= low ? pos - 1'b1 : pos;
        w_start  <= low ? prev_start : hdr_q;
        w_size   <= low ? lsize : nsize;
      end
    end
    if (state == ST_RESP && (!m_tvalid || m_tready)) begin
      grant_addr   <= res_addr;
      granted_size <= res_size;
      status       <= res_stat;
    end
  end

endmodule

/* design/bfsa_cell.sv */
// One link of the free-segment chain: holds a segment start and size and
// takes its neighbour's entry when the chain shifts. Uses bfsa_pkg.
module bfsa_cell #(
  parameter int ADDR_BITS = bfsa_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        shift,
  input  logic [ADDR_BITS-1:0]        in_start,
  input  logic [bfsa_pkg::SIZE_W-1:0] in_size,
  output logic [ADDR_BITS-1:0]        start,
  output logic [bfsa_pkg::SIZE_W-1:0] size
);
  import bfsa_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      start <= in_start;
      size  <= in_size;
    end
  end

endmodule
